[rtl/core/mssr_pkg.sv]
// Shared constants, codes and the lane control bundle for the set/reset sequencer.
package mssr_pkg;

    localparam int COUNT_W  = 20;
    localparam int UPPER_W  = 16;
    localparam int NIB_W    = 4;
    localparam int CENT_W   = 21;
    localparam int FIELD_W  = 28;
    localparam int LIMIT_W  = 11;
    localparam int PHASE_W  = 3;
    localparam int STATUS_W = 8;
    localparam int BYTE_W   = 8;
    localparam int LOWNIB_W = 24;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1000;

    localparam logic [CFG_IDX_W-1:0] CFG_VARIANT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 1'b1;

    localparam logic [BYTE_W-1:0] CMD_SET   = 8'h08;
    localparam logic [BYTE_W-1:0] CMD_RESET = 8'h10;
    localparam logic [BYTE_W-1:0] CMD_TAKE  = 8'h01;

    localparam logic [BYTE_W-1:0] ADDR_MAP16 = 8'h09;
    localparam logic [BYTE_W-1:0] ADDR_MAP20 = 8'h1B;

    localparam logic [STATUS_W-1:0] DONE_MAP16 = 8'h01;
    localparam logic [STATUS_W-1:0] DONE_MAP20 = 8'h40;

    typedef struct packed {
        logic variant;
        logic a_load;
        logic cap;
        logic b_load;
        logic c_load;
        logic c_pair;
        logic c_meas;
        logic off_known;
    } mssr_lane_ctl_t;

endpackage

[rtl/core/mssr_lane.sv]
// One axis lane: count unpacking, scaled products, offset tracking and field output.
module mssr_lane (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  mssr_pkg::mssr_lane_ctl_t               ctl,
    input  logic [mssr_pkg::UPPER_W-1:0]           upper,
    input  logic [mssr_pkg::NIB_W-1:0]             nibble,
    output logic signed [mssr_pkg::FIELD_W-1:0]    field
);
    import mssr_pkg::*;

    localparam int DIFF_W = CENT_W + 1;
    localparam int PROD_W = FIELD_W + 1;

    function automatic logic signed [CENT_W-1:0] centered(
        input logic [COUNT_W-1:0] comp,
        input logic               map20
    );
        logic signed [CENT_W-1:0] c20;
        logic signed [CENT_W-1:0] c16;
        begin
            c20 = {~comp[COUNT_W-1], ~comp[COUNT_W-1], comp[COUNT_W-2:0]};
            c16 = {{(CENT_W-UPPER_W+1){~comp[COUNT_W-1]}}, comp[COUNT_W-2:NIB_W]};
            centered = map20 ? c20 : c16;
        end
    endfunction

    logic [UPPER_W-1:0]          upper_reg;
    logic [NIB_W-1:0]            nib_reg;
    logic [COUNT_W-1:0]          set_comp_reg;
    logic signed [FIELD_W-1:0]   fpair_reg;
    logic signed [FIELD_W-1:0]   noff_reg;
    logic signed [FIELD_W-1:0]   fmeas_reg;
    logic signed [FIELD_W-1:0]   offset_reg;
    logic signed [FIELD_W-1:0]   offset_next;
    logic signed [FIELD_W-1:0]   field_reg;
    logic signed [FIELD_W-1:0]   field_next;

    logic [COUNT_W-1:0]          comp_now;
    logic signed [CENT_W-1:0]    c_now;
    logic signed [CENT_W-1:0]    c_set;
    logic signed [DIFF_W-1:0]    diff;
    logic signed [DIFF_W-1:0]    sum;
    logic signed [PROD_W-1:0]    diff_x;
    logic signed [PROD_W-1:0]    sum_x;
    logic signed [PROD_W-1:0]    now_x;
    logic signed [PROD_W-1:0]    diff_h;
    logic signed [PROD_W-1:0]    sum_h;
    logic signed [PROD_W-1:0]    now_s;
    logic signed [PROD_W-1:0]    avg_sum;
    logic signed [PROD_W-1:0]    avg_half;

    assign comp_now = {upper_reg, nib_reg};
    assign c_now    = centered(comp_now, ctl.variant);
    assign c_set    = centered(set_comp_reg, ctl.variant);

    assign diff   = {c_now[CENT_W-1], c_now} - {c_set[CENT_W-1], c_set};
    assign sum    = {c_now[CENT_W-1], c_now} + {c_set[CENT_W-1], c_set};
    assign diff_x = {{(PROD_W-DIFF_W){diff[DIFF_W-1]}}, diff};
    assign sum_x  = {{(PROD_W-DIFF_W){sum[DIFF_W-1]}}, sum};
    assign now_x  = {{(PROD_W-CENT_W){c_now[CENT_W-1]}}, c_now};

    // half scale: 32 or 125; full scale: 64 or 250
    assign diff_h = ctl.variant ? (diff_x <<< 5)
                                : (diff_x <<< 7) - (diff_x <<< 1) - diff_x;
    assign sum_h  = ctl.variant ? (sum_x <<< 5)
                                : (sum_x <<< 7) - (sum_x <<< 1) - sum_x;
    assign now_s  = ctl.variant ? (now_x <<< 6)
                                : (now_x <<< 8) - (now_x <<< 2) - (now_x <<< 1);

    assign avg_sum  = {offset_reg[FIELD_W-1], offset_reg} + {noff_reg[FIELD_W-1], noff_reg};
    assign avg_half = avg_sum >>> 1;

    always_comb
    begin
        offset_next = offset_reg;
        field_next  = '0;
        if (ctl.c_pair)
        begin
            field_next  = fpair_reg;
            offset_next = ctl.off_known ? avg_half[FIELD_W-1:0] : noff_reg;
        end
        else if (ctl.c_meas)
        begin
            field_next = fmeas_reg - offset_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
        end
        else if (ctl.c_load)
        begin
            offset_reg <= offset_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.a_load)
        begin
            upper_reg <= upper;
            nib_reg   <= nibble;
        end
        if (ctl.cap)
        begin
            set_comp_reg <= comp_now;
        end
        if (ctl.b_load)
        begin
            fpair_reg <= diff_h[FIELD_W-1:0];
            noff_reg  <= sum_h[FIELD_W-1:0];
            fmeas_reg <= now_s[FIELD_W-1:0];
        end
        if (ctl.c_load)
        begin
            field_reg <= field_next;
        end
    end

    assign field = field_reg;

endmodule

[rtl/core/mssr_seq.sv]
// Phase sequencer, configuration registers, pipeline handshake and write/sample merge.
module mssr_seq (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mssr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mssr_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                status_ok,
    input  logic [mssr_pkg::STATUS_W-1:0]       status_byte,
    input  logic                                data_ok,
    input  logic                                write_ok,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                write_issued,
    output logic [mssr_pkg::BYTE_W-1:0]         write_addr,
    output logic [mssr_pkg::BYTE_W-1:0]         write_value,
    output logic                                sample_valid,
    output logic [mssr_pkg::PHASE_W-1:0]        phase_now,
    output mssr_pkg::mssr_lane_ctl_t            lane_ctl
);
    import mssr_pkg::*;

    typedef enum logic [PHASE_W-1:0] {
        PH_SET      = 3'd0,
        PH_SET_MEAS = 3'd1,
        PH_SET_WAIT = 3'd2,
        PH_RST_MEAS = 3'd3,
        PH_RST_WAIT = 3'd4,
        PH_MEAS     = 3'd5
    } phase_t;

    phase_t               phase_reg, phase_next;
    logic                 variant_reg, variant_next;
    logic [LIMIT_W-1:0]   limit_reg, limit_next;
    logic [LIMIT_W-1:0]   count_reg, count_next;
    logic                 known_reg, known_next;

    logic                 a_valid_reg, a_valid_next;
    logic                 status_ok_reg, data_ok_reg, write_ok_reg;
    logic [STATUS_W-1:0]  status_byte_reg;

    logic                 b_valid_reg, b_valid_next;
    logic                 b_wr_reg, b_wr_next;
    logic [BYTE_W-1:0]    b_addr_reg, b_addr_next;
    logic [BYTE_W-1:0]    b_wval_reg, b_wval_next;
    logic                 b_pair_reg, b_pair_next;
    logic                 b_meas_reg, b_meas_next;
    logic [PHASE_W-1:0]   b_phase_reg, b_phase_next;

    logic                 c_valid_reg, c_valid_next;
    logic                 c_wr_reg, c_wr_next;
    logic [BYTE_W-1:0]    c_addr_reg, c_addr_next;
    logic [BYTE_W-1:0]    c_wval_reg, c_wval_next;
    logic                 c_sv_reg, c_sv_next;
    logic [PHASE_W-1:0]   c_phase_reg, c_phase_next;

    logic                 c_adv, b_adv, a_fire, b_fire, in_fire;
    logic                 done_hit, cap;
    logic                 wr;
    logic [BYTE_W-1:0]    wval;
    logic                 pair, meas;
    phase_t               ph_step;

    assign c_adv   = !c_valid_reg || !out_stall;
    assign b_adv   = !b_valid_reg || c_adv;
    assign a_fire  = a_valid_reg && b_adv;
    assign b_fire  = b_valid_reg && c_adv;
    assign in_stall = a_valid_reg && !b_adv;
    assign in_fire = in_valid && !in_stall;

    assign done_hit = |(status_byte_reg & (variant_reg ? DONE_MAP20 : DONE_MAP16));

    always_comb
    begin
        wr         = 1'b0;
        wval       = '0;
        pair       = 1'b0;
        meas       = 1'b0;
        cap        = 1'b0;
        ph_step    = phase_reg;
        count_next = count_reg;
        case (phase_reg)
            PH_SET_MEAS:
            begin
                wr   = 1'b1;
                wval = CMD_TAKE;
                if (write_ok_reg)
                    ph_step = PH_SET_WAIT;
            end
            PH_SET_WAIT:
            begin
                if (!status_ok_reg)
                    ph_step = PH_SET;
                else if (done_hit)
                begin
                    if (!data_ok_reg)
                        ph_step = PH_SET;
                    else
                    begin
                        cap  = 1'b1;
                        wr   = 1'b1;
                        wval = CMD_RESET;
                        if (write_ok_reg)
                            ph_step = PH_RST_MEAS;
                    end
                end
            end
            PH_RST_MEAS:
            begin
                wr      = 1'b1;
                wval    = CMD_TAKE;
                ph_step = write_ok_reg ? PH_RST_WAIT : PH_SET;
            end
            PH_RST_WAIT:
            begin
                if (!status_ok_reg)
                    ph_step = PH_SET;
                else if (done_hit)
                begin
                    if (!data_ok_reg)
                        ph_step = PH_SET;
                    else
                    begin
                        pair    = 1'b1;
                        wr      = 1'b1;
                        wval    = CMD_TAKE;
                        ph_step = write_ok_reg ? PH_MEAS : PH_SET;
                    end
                end
            end
            PH_MEAS:
            begin
                if (!status_ok_reg)
                    ph_step = PH_SET;
                else if (done_hit)
                begin
                    if (!data_ok_reg)
                        ph_step = PH_SET;
                    else
                    begin
                        meas = 1'b1;
                        if (count_reg >= limit_reg)
                        begin
                            count_next = '0;
                            ph_step    = PH_SET;
                        end
                        else
                        begin
                            count_next = count_reg + 1'b1;
                            wr         = 1'b1;
                            wval       = CMD_TAKE;
                            if (!write_ok_reg)
                                ph_step = PH_SET;
                        end
                    end
                end
            end
            default:
            begin
                wr      = 1'b1;
                wval    = CMD_SET;
                ph_step = write_ok_reg ? PH_SET_MEAS : PH_SET;
            end
        endcase
    end

    always_comb
    begin
        variant_next = variant_reg;
        limit_next   = limit_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_VARIANT: variant_next = cfg_data[0];
                CFG_LIMIT:   limit_next   = cfg_data[LIMIT_W-1:0];
                default:     limit_next   = limit_reg;
            endcase
        end

        a_valid_next = in_fire ? 1'b1 : (a_fire ? 1'b0 : a_valid_reg);
        b_valid_next = a_fire ? 1'b1 : (b_fire ? 1'b0 : b_valid_reg);
        c_valid_next = b_fire ? 1'b1 : (c_valid_reg && out_stall);

        b_wr_next    = wr;
        b_addr_next  = wr ? (variant_reg ? ADDR_MAP20 : ADDR_MAP16) : '0;
        b_wval_next  = wr ? wval : '0;
        b_pair_next  = pair;
        b_meas_next  = meas;
        b_phase_next = ph_step;

        c_wr_next    = b_wr_reg;
        c_addr_next  = b_addr_reg;
        c_wval_next  = b_wval_reg;
        c_sv_next    = b_pair_reg || b_meas_reg;
        c_phase_next = b_phase_reg;

        phase_next = a_fire ? ph_step : phase_reg;
        known_next = (b_fire && b_pair_reg) ? 1'b1 : known_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_SET;
            variant_reg     <= 1'b0;
            limit_reg       <= LIMIT_RESET;
            count_reg       <= '0;
            known_reg       <= 1'b0;
            a_valid_reg     <= 1'b0;
            status_ok_reg   <= 1'b0;
            status_byte_reg <= '0;
            data_ok_reg     <= 1'b0;
            write_ok_reg    <= 1'b0;
            b_valid_reg     <= 1'b0;
            b_wr_reg        <= 1'b0;
            b_addr_reg      <= '0;
            b_wval_reg      <= '0;
            b_pair_reg      <= 1'b0;
            b_meas_reg      <= 1'b0;
            b_phase_reg     <= '0;
            c_valid_reg     <= 1'b0;
            c_wr_reg        <= 1'b0;
            c_addr_reg      <= '0;
            c_wval_reg      <= '0;
            c_sv_reg        <= 1'b0;
            c_phase_reg     <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            variant_reg <= variant_next;
            limit_reg   <= limit_next;
            known_reg   <= known_next;
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
            if (a_fire)
                count_reg <= count_next;
            if (in_fire)
            begin
                status_ok_reg   <= status_ok;
                status_byte_reg <= status_byte;
                data_ok_reg     <= data_ok;
                write_ok_reg    <= write_ok;
            end
            if (a_fire)
            begin
                b_wr_reg    <= b_wr_next;
                b_addr_reg  <= b_addr_next;
                b_wval_reg  <= b_wval_next;
                b_pair_reg  <= b_pair_next;
                b_meas_reg  <= b_meas_next;
                b_phase_reg <= b_phase_next;
            end
            if (b_fire)
            begin
                c_wr_reg    <= c_wr_next;
                c_addr_reg  <= c_addr_next;
                c_wval_reg  <= c_wval_next;
                c_sv_reg    <= c_sv_next;
                c_phase_reg <= c_phase_next;
            end
        end
    end

    assign lane_ctl.variant   = variant_reg;
    assign lane_ctl.a_load    = in_fire;
    assign lane_ctl.cap       = a_fire && cap;
    assign lane_ctl.b_load    = a_fire;
    assign lane_ctl.c_load    = b_fire;
    assign lane_ctl.c_pair    = b_pair_reg;
    assign lane_ctl.c_meas    = b_meas_reg;
    assign lane_ctl.off_known = known_reg;

    assign out_valid    = c_valid_reg;
    assign write_issued = c_wr_reg;
    assign write_addr   = c_addr_reg;
    assign write_value  = c_wval_reg;
    assign sample_valid = c_sv_reg;
    assign phase_now    = c_phase_reg;

endmodule

[rtl/core/magnetometer_set_reset_sequencer_unit.sv]
// Top level of the set/reset offset-cancelling magnetometer sequencer.
// One item is one bus tick: the status, data and write outcomes seen in that step. The block
// takes one item per clock cycle when the output side keeps up, and each result passes
// through three register stages (input capture at the accepting edge, scaled products,
// output with offset update). The three axes run in identical lanes side by side; the
// sequencer holds the phase, the measurement counter and the configuration, and merges the write
// command with the lane fields. Fields are two's complement in 1/1024 mG and read zero when no
// sample is produced; write address and value read zero when no write is made. Configuration
// (index 0 variant, index 1 measure limit) must be written by the user only while no items are
// in flight; the block does not enforce this.
module magnetometer_set_reset_sequencer_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [mssr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mssr_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  status_ok,
    input  logic [mssr_pkg::STATUS_W-1:0]         status_byte,
    input  logic                                  data_ok,
    input  logic [mssr_pkg::UPPER_W-1:0]          x_upper,
    input  logic [mssr_pkg::UPPER_W-1:0]          y_upper,
    input  logic [mssr_pkg::UPPER_W-1:0]          z_upper,
    input  logic [mssr_pkg::LOWNIB_W-1:0]         low_nibbles,
    input  logic                                  write_ok,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  write_issued,
    output logic [mssr_pkg::BYTE_W-1:0]           write_addr,
    output logic [mssr_pkg::BYTE_W-1:0]           write_value,
    output logic                                  sample_valid,
    output logic signed [mssr_pkg::FIELD_W-1:0]   field_x,
    output logic signed [mssr_pkg::FIELD_W-1:0]   field_y,
    output logic signed [mssr_pkg::FIELD_W-1:0]   field_z,
    output logic [mssr_pkg::PHASE_W-1:0]          phase_now
);
    import mssr_pkg::*;

    mssr_lane_ctl_t lane_ctl;

    mssr_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .status_ok    (status_ok),
        .status_byte  (status_byte),
        .data_ok      (data_ok),
        .write_ok     (write_ok),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .write_issued (write_issued),
        .write_addr   (write_addr),
        .write_value  (write_value),
        .sample_valid (sample_valid),
        .phase_now    (phase_now),
        .lane_ctl     (lane_ctl)
    );

    mssr_lane u_lane_x (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (lane_ctl),
        .upper  (x_upper),
        .nibble (low_nibbles[23:20]),
        .field  (field_x)
    );

    mssr_lane u_lane_y (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (lane_ctl),
        .upper  (y_upper),
        .nibble (low_nibbles[15:12]),
        .field  (field_y)
    );

    mssr_lane u_lane_z (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (lane_ctl),
        .upper  (z_upper),
        .nibble (low_nibbles[7:4]),
        .field  (field_z)
    );

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the magnetometer set/reset sequencer.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mssr_pkg::*;

    typedef enum logic [PHASE_W-1:0] {
        SEQ_SET      = 3'd0,
        SEQ_SET_MEAS = 3'd1,
        SEQ_SET_WAIT = 3'd2,
        SEQ_RST_MEAS = 3'd3,
        SEQ_RST_WAIT = 3'd4,
        SEQ_MEAS     = 3'd5
    } seq_phase_e;

    typedef struct {
        logic                status_ok;
        logic [STATUS_W-1:0] status_byte;
        logic                data_ok;
        logic [UPPER_W-1:0]  x_upper;
        logic [UPPER_W-1:0]  y_upper;
        logic [UPPER_W-1:0]  z_upper;
        logic [LOWNIB_W-1:0] low_nibbles;
        logic                write_ok;
    } tick_t;

    typedef struct {
        logic                      write_issued;
        logic [BYTE_W-1:0]         write_addr;
        logic [BYTE_W-1:0]         write_value;
        logic                      sample_valid;
        logic signed [FIELD_W-1:0] field_x;
        logic signed [FIELD_W-1:0] field_y;
        logic signed [FIELD_W-1:0] field_z;
        logic [PHASE_W-1:0]        phase_now;
    } outcome_t;

    typedef struct {
        tick_t    tick;
        bit       typed;
        outcome_t want;
    } plan_row_t;

    logic                      clk;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [CFG_DATA_W-1:0]     cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic                      status_ok = 1'b0;
    logic [STATUS_W-1:0]       status_byte = '0;
    logic                      data_ok = 1'b0;
    logic [UPPER_W-1:0]        x_upper = '0;
    logic [UPPER_W-1:0]        y_upper = '0;
    logic [UPPER_W-1:0]        z_upper = '0;
    logic [LOWNIB_W-1:0]       low_nibbles = '0;
    logic                      write_ok = 1'b0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic                      write_issued;
    logic [BYTE_W-1:0]         write_addr;
    logic [BYTE_W-1:0]         write_value;
    logic                      sample_valid;
    logic signed [FIELD_W-1:0] field_x;
    logic signed [FIELD_W-1:0] field_y;
    logic signed [FIELD_W-1:0] field_z;
    logic [PHASE_W-1:0]        phase_now;

    magnetometer_set_reset_sequencer_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .status_ok    (status_ok),
        .status_byte  (status_byte),
        .data_ok      (data_ok),
        .x_upper      (x_upper),
        .y_upper      (y_upper),
        .z_upper      (z_upper),
        .low_nibbles  (low_nibbles),
        .write_ok     (write_ok),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .write_issued (write_issued),
        .write_addr   (write_addr),
        .write_value  (write_value),
        .sample_valid (sample_valid),
        .field_x      (field_x),
        .field_y      (field_y),
        .field_z      (field_z),
        .phase_now    (phase_now)
    );

    // predictor state and configuration
    logic               cfg_variant = 1'b0;
    logic [LIMIT_W-1:0] cfg_limit = LIMIT_RESET;
    seq_phase_e         seq_ph = SEQ_SET;
    logic [COUNT_W-1:0] held_counts [3];
    longint             zero_offset [3] = '{0, 0, 0};
    logic               offset_valid = 1'b0;
    logic [LIMIT_W-1:0] meas_count = '0;

    outcome_t    owed_outcomes [$];
    plan_row_t   plan [$];
    int          fault_count = 0;
    int          burst_left = 0;
    int          stall_mode = 0;
    int          stall_left = 0;
    int          rx_cycle = 0;
    outcome_t    head;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic longint counts_from_zero(input logic [COUNT_W-1:0] c);
        if (cfg_variant)
            return longint'(c) - 524288;
        return longint'(c[COUNT_W-1:NIB_W]) - 32768;
    endfunction

    function automatic outcome_t step_sequencer(input tick_t t);
        outcome_t           r;
        logic [COUNT_W-1:0] now_c [3];
        longint             fld [3];
        longint             scl;
        longint             f1;
        longint             f2;
        longint             noff;
        logic [STATUS_W-1:0] done_bit;
        logic [BYTE_W-1:0]  addr;
        logic [BYTE_W-1:0]  wval;
        logic               wr;
        logic               sv;
        now_c[0] = {t.x_upper, t.low_nibbles[23:20]};
        now_c[1] = {t.y_upper, t.low_nibbles[15:12]};
        now_c[2] = {t.z_upper, t.low_nibbles[7:4]};
        done_bit = cfg_variant ? DONE_MAP20 : DONE_MAP16;
        addr = cfg_variant ? ADDR_MAP20 : ADDR_MAP16;
        scl = cfg_variant ? 64 : 250;
        wr = 1'b0;
        sv = 1'b0;
        wval = '0;
        fld = '{0, 0, 0};
        case (seq_ph)
            SEQ_SET_MEAS:
            begin
                wr = 1'b1;
                wval = CMD_TAKE;
                if (t.write_ok)
                    seq_ph = SEQ_SET_WAIT;
            end
            SEQ_SET_WAIT:
            begin
                if (!t.status_ok)
                    seq_ph = SEQ_SET;
                else if ((t.status_byte & done_bit) == '0)
                    seq_ph = SEQ_SET_WAIT;
                else if (!t.data_ok)
                    seq_ph = SEQ_SET;
                else
                begin
                    for (int i = 0; i < 3; i++)
                        held_counts[i] = now_c[i];
                    wr = 1'b1;
                    wval = CMD_RESET;
                    if (t.write_ok)
                        seq_ph = SEQ_RST_MEAS;
                end
            end
            SEQ_RST_MEAS:
            begin
                wr = 1'b1;
                wval = CMD_TAKE;
                seq_ph = t.write_ok ? SEQ_RST_WAIT : SEQ_SET;
            end
            SEQ_RST_WAIT:
            begin
                if (!t.status_ok)
                    seq_ph = SEQ_SET;
                else if ((t.status_byte & done_bit) == '0)
                    seq_ph = SEQ_RST_WAIT;
                else if (!t.data_ok)
                    seq_ph = SEQ_SET;
                else
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        f1 = counts_from_zero(held_counts[i]);
                        f2 = counts_from_zero(now_c[i]);
                        noff = (f1 + f2) * (scl / 2);
                        fld[i] = (f2 - f1) * (scl / 2);
                        zero_offset[i] = offset_valid ? (zero_offset[i] + noff) >>> 1 : noff;
                    end
                    offset_valid = 1'b1;
                    sv = 1'b1;
                    wr = 1'b1;
                    wval = CMD_TAKE;
                    seq_ph = t.write_ok ? SEQ_MEAS : SEQ_SET;
                end
            end
            SEQ_MEAS:
            begin
                if (!t.status_ok)
                    seq_ph = SEQ_SET;
                else if ((t.status_byte & done_bit) == '0)
                    seq_ph = SEQ_MEAS;
                else if (!t.data_ok)
                    seq_ph = SEQ_SET;
                else
                begin
                    for (int i = 0; i < 3; i++)
                        fld[i] = counts_from_zero(now_c[i]) * scl - zero_offset[i];
                    sv = 1'b1;
                    if (meas_count >= cfg_limit)
                    begin
                        meas_count = '0;
                        seq_ph = SEQ_SET;
                    end
                    else
                    begin
                        meas_count = meas_count + 1'b1;
                        wr = 1'b1;
                        wval = CMD_TAKE;
                        if (!t.write_ok)
                            seq_ph = SEQ_SET;
                    end
                end
            end
            default:
            begin
                wr = 1'b1;
                wval = CMD_SET;
                seq_ph = t.write_ok ? SEQ_SET_MEAS : SEQ_SET;
            end
        endcase
        r.write_issued = wr;
        r.write_addr = wr ? addr : '0;
        r.write_value = wr ? wval : '0;
        r.sample_valid = sv;
        r.field_x = sv ? fld[0][FIELD_W-1:0] : '0;
        r.field_y = sv ? fld[1][FIELD_W-1:0] : '0;
        r.field_z = sv ? fld[2][FIELD_W-1:0] : '0;
        r.phase_now = seq_ph;
        return r;
    endfunction

    function automatic logic [UPPER_W-1:0] pick_upper();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000 + 16'($urandom_range(0, 15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic tick_t random_tick();
        tick_t               t;
        logic [STATUS_W-1:0] done_bit;
        int                  roll;
        done_bit = cfg_variant ? DONE_MAP20 : DONE_MAP16;
        t.x_upper = pick_upper();
        t.y_upper = pick_upper();
        t.z_upper = pick_upper();
        t.low_nibbles = 24'($urandom);
        if ($urandom_range(0, 99) < 10)
        begin
            t.status_ok = 1'($urandom);
            t.status_byte = 8'($urandom);
            t.data_ok = 1'($urandom);
            t.write_ok = 1'($urandom);
        end
        else
        begin
            t.status_ok = 1'b1;
            t.status_byte = 8'($urandom) | done_bit;
            t.data_ok = 1'b1;
            t.write_ok = 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < 4)
                t.status_ok = 1'b0;
            else if (roll < 8)
                t.data_ok = 1'b0;
            else if (roll < 14)
                t.write_ok = 1'b0;
            else if (roll < 20)
                t.status_byte = t.status_byte & ~done_bit;
        end
        return t;
    endfunction

    task automatic add_row(input logic so, input logic [7:0] sb, input logic dok,
                           input logic [15:0] xu, input logic [15:0] yu,
                           input logic [15:0] zu, input logic [23:0] nib,
                           input logic wok, input bit typed, input logic wr,
                           input logic [7:0] wval, input seq_phase_e ph);
        plan_row_t row;
        row.tick = '{so, sb, dok, xu, yu, zu, nib, wok};
        row.typed = typed;
        row.want.write_issued = wr;
        row.want.write_addr = wr ? ADDR_MAP16 : 8'h00;
        row.want.write_value = wval;
        row.want.sample_valid = 1'b0;
        row.want.field_x = '0;
        row.want.field_y = '0;
        row.want.field_z = '0;
        row.want.phase_now = ph;
        plan.push_back(row);
    endtask

    task automatic send_tick(input tick_t t);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        status_ok <= t.status_ok;
        status_byte <= t.status_byte;
        data_ok <= t.data_ok;
        x_upper <= t.x_upper;
        y_upper <= t.y_upper;
        z_upper <= t.z_upper;
        low_nibbles <= t.low_nibbles;
        write_ok <= t.write_ok;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic issue_tick(input tick_t t, input bit typed, input outcome_t want);
        outcome_t got;
        got = step_sequencer(t);
        owed_outcomes.push_back(typed ? want : got);
        send_tick(t);
    endtask

    // hold the sender until every owed outcome is back and the pipeline is empty
    task automatic settle();
        in_valid <= 1'b0;
        burst_left = 0;
        while (owed_outcomes.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == CFG_VARIANT)
            cfg_variant = val[0];
        else
            cfg_limit = val[LIMIT_W-1:0];
    endtask

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        fault_count++;
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    endtask

    task automatic check_field(input string what, input longint got, input longint want);
        if (got != want)
            flag_mismatch(what, got, want);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(20, 200);
            end
            stall_left--;
            rx_cycle++;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= ((rx_cycle % 5) < 2);
            endcase
            if (out_valid && !out_stall)
            begin
                if (owed_outcomes.size() == 0)
                    flag_mismatch("result with nothing owed", phase_now, 0);
                else
                begin
                    head = owed_outcomes.pop_front();
                    check_field("write_issued", write_issued, head.write_issued);
                    check_field("write_addr", write_addr, head.write_addr);
                    check_field("write_value", write_value, head.write_value);
                    check_field("sample_valid", sample_valid, head.sample_valid);
                    check_field("field_x", field_x, head.field_x);
                    check_field("field_y", field_y, head.field_y);
                    check_field("field_z", field_z, head.field_z);
                    check_field("phase_now", phase_now, head.phase_now);
                end
            end
        end
    end

    initial
    begin : stimulus
        int                 run_variant [6];
        int                 run_limit [6];
        outcome_t           none;
        int                 waited;
        run_variant = '{1, 0, 1, 1, 0, 0};
        run_limit = '{1, 2047, 2047, 3, 1, 1000};
        none = '{1'b0, 8'h00, 8'h00, 1'b0, 28'sd0, 28'sd0, 28'sd0, 3'd0};

        add_row(0, 8'h00, 0, 16'h0000, 16'h0000, 16'h0000, 24'h000000, 1,
                1, 1, CMD_SET, SEQ_SET_MEAS);
        add_row(0, 8'h00, 0, 16'h0000, 16'h0000, 16'h0000, 24'h000000, 0,
                1, 1, CMD_TAKE, SEQ_SET_MEAS);
        add_row(0, 8'h00, 0, 16'h0000, 16'h0000, 16'h0000, 24'h000000, 1,
                1, 1, CMD_TAKE, SEQ_SET_WAIT);
        add_row(0, 8'h01, 1, 16'h0000, 16'h0000, 16'h0000, 24'h000000, 1,
                1, 0, 8'h00, SEQ_SET);
        add_row(1, 8'hFF, 1, 16'h0000, 16'h0000, 16'h0000, 24'h000000, 0,
                1, 1, CMD_SET, SEQ_SET);
        add_row(1, 8'h01, 1, 16'h0000, 16'h0000, 16'h0000, 24'h000000, 1,
                1, 1, CMD_SET, SEQ_SET_MEAS);
        add_row(1, 8'h01, 1, 16'h0000, 16'h0000, 16'h0000, 24'h000000, 1,
                1, 1, CMD_TAKE, SEQ_SET_WAIT);
        add_row(1, 8'hFE, 1, 16'h0000, 16'h0000, 16'h0000, 24'h000000, 1,
                1, 0, 8'h00, SEQ_SET_WAIT);
        add_row(1, 8'h01, 0, 16'h0000, 16'h0000, 16'h0000, 24'h000000, 1,
                1, 0, 8'h00, SEQ_SET);
        add_row(1, 8'h01, 1, 16'h0000, 16'h0000, 16'h0000, 24'h000000, 1,
                1, 1, CMD_SET, SEQ_SET_MEAS);
        add_row(1, 8'h01, 1, 16'h0000, 16'h0000, 16'h0000, 24'h000000, 1,
                1, 1, CMD_TAKE, SEQ_SET_WAIT);
        add_row(1, 8'h01, 1, 16'hFFFF, 16'h0000, 16'h8000, 24'h000000, 0,
                1, 1, CMD_RESET, SEQ_SET_WAIT);
        add_row(1, 8'hFF, 1, 16'h0000, 16'hFFFF, 16'h7FFF, 24'hFFFFFF, 1,
                1, 1, CMD_RESET, SEQ_RST_MEAS);
        add_row(1, 8'h01, 1, 16'h0000, 16'h0000, 16'h0000, 24'h000000, 0,
                1, 1, CMD_TAKE, SEQ_SET);
        add_row(1, 8'h01, 1, 16'h0000, 16'h0000, 16'h0000, 24'h000000, 1,
                1, 1, CMD_SET, SEQ_SET_MEAS);
        add_row(1, 8'h01, 1, 16'h0000, 16'h0000, 16'h0000, 24'h000000, 1,
                1, 1, CMD_TAKE, SEQ_SET_WAIT);
        add_row(1, 8'h01, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 1,
                1, 1, CMD_RESET, SEQ_RST_MEAS);
        add_row(0, 8'h00, 0, 16'h0000, 16'h0000, 16'h0000, 24'h000000, 1,
                1, 1, CMD_TAKE, SEQ_RST_WAIT);
        add_row(1, 8'h01, 1, 16'h0000, 16'h0000, 16'h0000, 24'h000000, 0,
                0, 0, 8'h00, SEQ_SET);
        add_row(1, 8'h01, 1, 16'h0000, 16'h0000, 16'h0000, 24'h000000, 1,
                1, 1, CMD_SET, SEQ_SET_MEAS);
        add_row(1, 8'h01, 1, 16'h0000, 16'h0000, 16'h0000, 24'h000000, 1,
                1, 1, CMD_TAKE, SEQ_SET_WAIT);
        add_row(1, 8'h01, 1, 16'h8000, 16'h8000, 16'h8000, 24'h000000, 1,
                1, 1, CMD_RESET, SEQ_RST_MEAS);
        add_row(1, 8'h01, 1, 16'h0000, 16'h0000, 16'h0000, 24'h000000, 1,
                1, 1, CMD_TAKE, SEQ_RST_WAIT);
        add_row(1, 8'h41, 1, 16'h8001, 16'h7FFF, 16'h1234, 24'hABCDEF, 1,
                0, 0, 8'h00, SEQ_SET);
        add_row(1, 8'h01, 1, 16'hFFFF, 16'h0000, 16'h8000, 24'h5A5A5A, 1,
                0, 0, 8'h00, SEQ_SET);
        add_row(1, 8'hFE, 1, 16'h0000, 16'h0000, 16'h0000, 24'h000000, 1,
                1, 0, 8'h00, SEQ_MEAS);
        add_row(1, 8'h81, 1, 16'h0123, 16'hFEDC, 16'h8000, 24'h000000, 0,
                0, 0, 8'h00, SEQ_SET);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(CFG_VARIANT, 11'd0);
        write_reg(CFG_LIMIT, 11'd2);
        foreach (plan[i])
            issue_tick(plan[i].tick, plan[i].typed, plan[i].want);

        for (int p = 0; p < 6; p++)
        begin
            settle();
            write_reg(CFG_VARIANT, 11'(run_variant[p]));
            write_reg(CFG_LIMIT, 11'(run_limit[p]));
            for (int n = 0; n < 100; n++)
            begin
                if ($urandom_range(0, 199) == 0)
                    settle();
                issue_tick(random_tick(), 1'b0, none);
            end
        end

        in_valid <= 1'b0;
        waited = 0;
        while (owed_outcomes.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
        while (owed_outcomes.size() != 0)
        begin
            head = owed_outcomes.pop_front();
            flag_mismatch("outcome never delivered", 0, head.phase_now);
        end
        if (fault_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
